@@ sv/cci_pkg.sv @@
// shared types and constants for the calibration curve interpolator
// used by cci_mul_div and calibration_curve_interpolator; no dependencies
package cci_pkg;

    localparam int NUM_CURVES_DEF = 64;
    localparam int MAX_POINTS_DEF = 8;

    localparam int XW = 16;          // power / x width
    localparam int YW = 8;           // adc / index / y width
    localparam int PW = XW + YW;     // product width
    localparam int NPW = 4;          // num_points register width
    localparam logic [NPW-1:0] NUM_POINTS_RST = 4'd8;

    typedef enum logic [1:0] {
        FUNC_WR_POINT   = 2'd0,
        FUNC_WR_MAX     = 2'd1,
        FUNC_PWR_TO_ADC = 2'd2,
        FUNC_ADC_TO_IDX = 2'd3
    } func_t;

    typedef struct packed {
        logic          start;
        logic [XW-1:0] t;        // x - x0
        logic [XW-1:0] dx;       // x1 - x0, nonzero
        logic [YW-1:0] dy_mag;   // |y1 - y0|
    } md_req_t;

    typedef struct packed {
        logic          done;
        logic [YW-1:0] quo;
        logic          rem_nz;
    } md_rsp_t;

endpackage

@@ sv/cci_mul_div.sv @@
// bit-serial multiply then restoring divide: floor(t * dy_mag / dx)
// depends on cci_pkg; t < dx so the quotient fits in YW bits
module cci_mul_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cci_pkg::md_req_t  req,
    output cci_pkg::md_rsp_t  rsp
);

    localparam int XW = cci_pkg::XW;
    localparam int YW = cci_pkg::YW;
    localparam int PW = cci_pkg::PW;
    localparam int CNW = $clog2(YW);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t        state_reg, state_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [XW-1:0]    mcand_reg;
    logic [XW-1:0]    dx_reg;
    logic [YW-1:0]    shift_reg;
    logic [PW-1:0]    acc_reg;
    logic [XW-1:0]    rem_reg;
    logic [YW-1:0]    quo_reg;

    logic [PW-1:0]    acc_step;
    logic [XW:0]      trial;
    logic [XW:0]      diff;
    logic             ge;

    assign acc_step = {acc_reg[PW-2:0], 1'b0}
                    + (shift_reg[YW-1] ? {{YW{1'b0}}, mcand_reg} : {PW{1'b0}});
    assign trial = {rem_reg, shift_reg[YW-1]};
    assign diff  = trial - {1'b0, dx_reg};
    assign ge    = trial >= {1'b0, dx_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    state_next = MD_MUL;
                    cnt_next   = '0;
                end
            end
            MD_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNW'(YW - 1)) begin
                    state_next = MD_DIV;
                    cnt_next   = '0;
                end
            end
            MD_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNW'(YW - 1)) begin
                    state_next = MD_IDLE;
                    cnt_next   = '0;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    mcand_reg <= req.t;
                    dx_reg    <= req.dx;
                    shift_reg <= req.dy_mag;
                    acc_reg   <= '0;
                end
            end
            MD_MUL: begin
                if (cnt_reg == CNW'(YW - 1)) begin
                    rem_reg   <= acc_step[PW-1:YW];
                    shift_reg <= acc_step[YW-1:0];
                end else begin
                    acc_reg   <= acc_step;
                    shift_reg <= {shift_reg[YW-2:0], 1'b0};
                end
            end
            MD_DIV: begin
                rem_reg   <= ge ? diff[XW-1:0] : trial[XW-1:0];
                quo_reg   <= {quo_reg[YW-2:0], ge};
                shift_reg <= {shift_reg[YW-2:0], 1'b0};
            end
            default: begin
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = rem_reg != '0;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == MD_IDLE)
        else $error("divider started while busy");
    a_done_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg == MD_DIV))
        else $error("divider done without a divide phase");
    a_rem_below_dx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MD_DIV) |-> rem_reg < dx_reg)
        else $error("partial remainder not below divisor");
`endif

endmodule

@@ sv/calibration_curve_interpolator.sv @@
// calibration curve interpolator: point store, segment search, serial interpolation
// depends on cci_pkg and cci_mul_div
//
// usage: one input word per item on the s_ channel; func in s_tuser selects a point
// write, a curve maximum write, a power-to-adc lookup or an adc-to-index lookup.
// writes complete in the accept cycle and give no output word. each lookup gives
// one word on the m_ channel holding the 8-bit result.
// num_points is set through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, and the block itself does not enforce this. a lookup that clamps or
// hits the last point skips the multiply and divide; an interpolated one runs them.
// lookup time is set by the point memory read port (one point per cycle) and by the
// bit-serial multiply and divide. a lookup on a curve out of range skips the scan, goes
// straight to the done state and answers 0. one item is worked on at a time;
// s_tready is high while no lookup is in progress, so the next item is taken while a
// result word still waits in the output register.
// reset: control state clears and num_points returns to 8; stored points and
// curve maxima are undefined until written.
// stall: a held m_tready keeps the result word in place; a lookup that finishes
// meanwhile waits for the output register and holds off s_tready.
module calibration_curve_interpolator #(
    parameter int NUM_CURVES = cci_pkg::NUM_CURVES_DEF,
    parameter int MAX_POINTS = cci_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // curve_select[5:0] point_select[8:6] power_value[24:9]
                                   // adc_value[32:25] index_value[40:33]
                                   // max_index_value[48:41] zero[55:49]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // result_value[7:0]
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata  // num_points[3:0]
);

    localparam int XW = cci_pkg::XW;
    localparam int YW = cci_pkg::YW;
    localparam int NPW = cci_pkg::NPW;
    localparam int DEPTH = NUM_CURVES * MAX_POINTS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
    localparam int KW = $clog2(MAX_POINTS + 1);
    localparam int MW = XW + 2 * YW;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_MATH = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // input fields
    logic [5:0]           s_curve;
    logic [2:0]           s_point;
    logic signed [XW-1:0] s_power;
    logic [YW-1:0]        s_adc;
    logic [YW-1:0]        s_index;
    logic [YW-1:0]        s_max;
    cci_pkg::func_t       s_func;

    assign s_curve = s_tdata[5:0];
    assign s_point = s_tdata[8:6];
    assign s_power = s_tdata[24:9];
    assign s_adc   = s_tdata[32:25];
    assign s_index = s_tdata[40:33];
    assign s_max   = s_tdata[48:41];
    assign s_func  = cci_pkg::func_t'(s_tuser);

    state_t               state_reg, state_next;
    logic [NPW-1:0]       num_points_reg;
    logic [KW-1:0]        issue_k_reg, issue_k_next;
    logic                 rd_valid_reg, rd_last_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [YW-1:0]        m_tdata_reg;

    logic                 is_p2a_reg;
    logic [5:0]           curve_reg;
    logic signed [XW-1:0] x_reg;
    logic [YW-1:0]        cmax_reg;
    logic [MW-1:0]        rd_data_reg;
    logic                 first_ge_reg;
    logic [YW-1:0]        first_y_reg;
    logic signed [XW-1:0] prev_x_reg;
    logic [YW-1:0]        prev_y_reg;
    logic                 found_reg;
    logic signed [XW-1:0] seg_x0_reg, seg_x1_reg;
    logic [YW-1:0]        seg_y0_reg, seg_y1_reg;
    logic                 dy_neg_reg;
    logic [YW-1:0]        res_reg;

    logic [MW-1:0]        point_mem [DEPTH];
    logic [YW-1:0]        cmax_mem [NUM_CURVES];

    logic                 accept;
    logic                 curve_ok;
    logic                 point_ok;
    logic [KW-1:0]        n_use;
    logic                 issue;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic signed [XW-1:0] rd_x;
    logic [YW-1:0]        rd_y;
    logic                 out_free;
    logic [XW:0]          t_full, dx_full;
    logic signed [YW:0]   dy;
    logic [YW-1:0]        eval_res;
    logic                 eval_interp;
    logic [YW-1:0]        math_res;

    cci_pkg::md_req_t     md_req;
    cci_pkg::md_rsp_t     md_rsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign curve_ok = 32'(s_curve) < NUM_CURVES;
    assign point_ok = 32'(s_point) < MAX_POINTS;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (num_points_reg < NPW'(2)) begin
            n_use = KW'(2);
        end else if (32'(num_points_reg) > MAX_POINTS) begin
            n_use = KW'(MAX_POINTS);
        end else begin
            n_use = KW'(num_points_reg);
        end
    end

    assign issue   = (state_reg == ST_SCAN) && (issue_k_reg < n_use);
    assign rd_addr = AW'(32'(curve_reg) * MAX_POINTS + 32'(issue_k_reg));
    assign wr_addr = AW'(32'(s_curve) * MAX_POINTS + 32'(s_point));

    assign rd_x = is_p2a_reg ? $signed(rd_data_reg[XW-1:0])
                             : $signed({{(XW-YW){1'b0}}, rd_data_reg[XW+YW-1:XW]});
    assign rd_y = is_p2a_reg ? rd_data_reg[XW+YW-1:XW] : rd_data_reg[MW-1:XW+YW];

    // point memory: {index, adc, power}
    always_ff @(posedge aclk) begin
        if (accept && s_func == cci_pkg::FUNC_WR_POINT && curve_ok && point_ok) begin
            point_mem[wr_addr] <= {s_index, s_adc, s_power};
        end
        if (issue) begin
            rd_data_reg <= point_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_func == cci_pkg::FUNC_WR_MAX && curve_ok) begin
            cmax_mem[CW'(s_curve)] <= s_max;
        end
        if (accept && s_func == cci_pkg::FUNC_ADC_TO_IDX && curve_ok) begin
            cmax_reg <= cmax_mem[CW'(s_curve)];
        end
    end

    // segment evaluation
    assign t_full  = {x_reg[XW-1], x_reg} - {seg_x0_reg[XW-1], seg_x0_reg};
    assign dx_full = {seg_x1_reg[XW-1], seg_x1_reg} - {seg_x0_reg[XW-1], seg_x0_reg};
    assign dy      = $signed({1'b0, seg_y1_reg}) - $signed({1'b0, seg_y0_reg});

    always_comb begin
        eval_interp = 1'b0;
        priority if (first_ge_reg) begin
            eval_res = is_p2a_reg ? first_y_reg : '0;
        end else if (prev_x_reg < x_reg) begin
            eval_res = is_p2a_reg ? prev_y_reg : cmax_reg;
        end else if (!found_reg) begin
            eval_res = prev_y_reg;
        end else begin
            eval_res    = prev_y_reg;
            eval_interp = 1'b1;
        end
    end

    always_comb begin
        md_req.start  = (state_reg == ST_EVAL) && eval_interp;
        md_req.t      = t_full[XW-1:0];
        md_req.dx     = dx_full[XW-1:0];
        md_req.dy_mag = dy[YW] ? YW'(-dy) : dy[YW-1:0];
    end

    assign math_res = dy_neg_reg ? seg_y0_reg - md_rsp.quo - YW'(md_rsp.rem_nz)
                                 : seg_y0_reg + md_rsp.quo;

    cci_mul_div u_mul_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        issue_k_next  = issue_k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_func == cci_pkg::FUNC_PWR_TO_ADC ||
                               s_func == cci_pkg::FUNC_ADC_TO_IDX)) begin
                    state_next   = curve_ok ? ST_SCAN : ST_DONE;
                    issue_k_next = '0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    issue_k_next = issue_k_reg + 1'b1;
                end
                if (rd_valid_reg && rd_last_reg) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = eval_interp ? ST_MATH : ST_DONE;
            end
            ST_MATH: begin
                if (md_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_k_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            num_points_reg <= cci_pkg::NUM_POINTS_RST;
        end else begin
            state_reg    <= state_next;
            issue_k_reg  <= issue_k_next;
            rd_valid_reg <= issue;
            rd_last_reg  <= issue && (issue_k_reg == n_use - 1'b1);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                num_points_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            is_p2a_reg <= s_func == cci_pkg::FUNC_PWR_TO_ADC;
            curve_reg  <= s_curve;
            x_reg      <= (s_func == cci_pkg::FUNC_PWR_TO_ADC) ? s_power
                        : $signed({{(XW-YW){1'b0}}, s_adc});
            found_reg  <= 1'b0;
            res_reg    <= '0;
        end
        if (rd_valid_reg) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (!found_reg && rd_x > x_reg) begin
                found_reg  <= 1'b1;
                seg_x0_reg <= prev_x_reg;
                seg_y0_reg <= prev_y_reg;
                seg_x1_reg <= rd_x;
                seg_y1_reg <= rd_y;
            end
        end
        if (state_reg == ST_EVAL) begin
            res_reg    <= eval_res;
            dy_neg_reg <= dy[YW];
        end
        if (state_reg == ST_MATH && md_rsp.done) begin
            res_reg <= math_res;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= res_reg;
        end
    end

    // first point of the scan: tracked by a flag set at acceptance
    logic first_pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pending_reg <= 1'b0;
        end else if (state_reg == ST_IDLE && accept) begin
            first_pending_reg <= 1'b1;
        end else if (rd_valid_reg) begin
            first_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && first_pending_reg) begin
            first_ge_reg <= rd_x >= x_reg;
            first_y_reg  <= rd_y;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> state_reg == ST_SCAN)
        else $error("point data returned outside the scan");
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside the done state");
    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == cci_pkg::FUNC_WR_POINT || s_func == cci_pkg::FUNC_WR_MAX))
        |=> state_reg == ST_IDLE)
        else $error("write item left the idle state");
    a_done_in_math: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> state_reg == ST_MATH)
        else $error("divider finished outside the math state");
`endif

endmodule

@@ bench/tb_calibration_curve_interpolator.sv @@
`timescale 1ns / 1ps
// self-checking bench for calibration_curve_interpolator: a directed table, then random
// curve writes and lookups over several num_points settings, scored by an in-bench model
// depends on cci_pkg and the calibration_curve_interpolator rtl
module tb_calibration_curve_interpolator;

    localparam int NUM_CV = cci_pkg::NUM_CURVES_DEF;
    localparam int MAX_PTS = cci_pkg::MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_WORDS = 100;

    localparam cci_pkg::func_t WR_PT = cci_pkg::FUNC_WR_POINT;
    localparam cci_pkg::func_t WR_MX = cci_pkg::FUNC_WR_MAX;
    localparam cci_pkg::func_t P2A   = cci_pkg::FUNC_PWR_TO_ADC;
    localparam cci_pkg::func_t A2I   = cci_pkg::FUNC_ADC_TO_IDX;

    typedef struct packed {
        cci_pkg::func_t     func;
        logic [5:0]         curve;
        logic [2:0]         point;
        logic signed [15:0] power;
        logic [7:0]         adc;
        logic [7:0]         idx;
        logic [7:0]         maxi;
    } cal_word_t;

    typedef struct packed {
        cal_word_t  word;
        logic       checked;
        logic [7:0] want;
    } dir_row_t;

    // curve 5 gets a full ordered curve, then clamps, exact points and segments are read back
    localparam dir_row_t DIR_ROWS [21] = '{
        '{'{WR_PT, 6'd5,  3'd0, 16'h8000,    8'd0,   8'd255, 8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd1, -16'sd20000, 8'd5,   8'd200, 8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd2, -16'sd100,   8'd40,  8'd150, 8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd3, 16'sd0,      8'd60,  8'd100, 8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd4, 16'sd50,     8'd100, 8'd80,  8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd5, 16'sd1000,   8'd180, 8'd30,  8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd6, 16'sd20000,  8'd200, 8'd10,  8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd5,  3'd7, 16'h7fff,    8'd240, 8'd0,   8'd0},   1'b0, 8'd0},
        '{'{WR_MX, 6'd5,  3'd0, 16'sd0,      8'd0,   8'd0,   8'hab},  1'b0, 8'd0},
        '{'{P2A,   6'd5,  3'd0, 16'h8000,    8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
        '{'{P2A,   6'd5,  3'd0, 16'h7fff,    8'd0,   8'd0,   8'd0},   1'b1, 8'd240},
        '{'{P2A,   6'd5,  3'd0, 16'sd25,     8'd0,   8'd0,   8'd0},   1'b0, 8'd0},
        '{'{P2A,   6'd5,  3'd0, 16'h8001,    8'd0,   8'd0,   8'd0},   1'b0, 8'd0},
        '{'{P2A,   6'd5,  3'd0, -16'sd100,   8'd0,   8'd0,   8'd0},   1'b0, 8'd0},
        '{'{A2I,   6'd5,  3'd0, 16'sd0,      8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
        '{'{A2I,   6'd5,  3'd0, 16'sd0,      8'd255, 8'd0,   8'd0},   1'b1, 8'hab},
        '{'{A2I,   6'd5,  3'd0, 16'sd0,      8'd240, 8'd0,   8'd0},   1'b1, 8'd0},
        '{'{A2I,   6'd5,  3'd0, 16'sd0,      8'd70,  8'd0,   8'd0},   1'b0, 8'd0},
        '{'{A2I,   6'd5,  3'd0, 16'sd0,      8'd1,   8'd0,   8'd0},   1'b0, 8'd0},
        '{'{WR_PT, 6'd63, 3'd7, 16'hffff,    8'hff,  8'hff,  8'hff},  1'b0, 8'd0},
        '{'{WR_MX, 6'd63, 3'd7, 16'hffff,    8'hff,  8'hff,  8'hff},  1'b0, 8'd0}
    };

    localparam logic [3:0] NPTS_PLAN [9] = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd3, 4'd7,
                                             4'd8};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // curve_select, point_select, power_value, adc_value,
                            // index_value, max_index_value, zero fill
    logic [1:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // result_value
    logic        cfg_we;
    logic [3:0]  cfg_wdata;

    logic signed [15:0] pwr_tbl [NUM_CV][MAX_PTS];
    logic [7:0]         adc_tbl [NUM_CV][MAX_PTS];
    logic [7:0]         idx_tbl [NUM_CV][MAX_PTS];
    logic [7:0]         max_tbl [NUM_CV];
    logic [3:0]         npts_reg;

    logic [7:0] lookup_answers [$];
    logic [7:0] want_word;
    int         fails = 0;
    int         words_sent = 0;
    int         cycle_count = 0;
    bit         quiet = 1'b0;

    calibration_curve_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic int points_used();
        if (npts_reg < 2) return 2;
        if (npts_reg > MAX_PTS) return MAX_PTS;
        return int'(npts_reg);
    endfunction

    function automatic logic [7:0] interpolate_curve(input cal_word_t w);
        int     n;
        int     i;
        longint xs [MAX_PTS];
        longint ys [MAX_PTS];
        longint x, below, above, x0, dx, dy, q;
        n = points_used();
        for (int k = 0; k < n; k++) begin
            if (w.func == cci_pkg::FUNC_PWR_TO_ADC) begin
                xs[k] = pwr_tbl[w.curve][k];
                ys[k] = adc_tbl[w.curve][k];
            end else begin
                xs[k] = adc_tbl[w.curve][k];
                ys[k] = idx_tbl[w.curve][k];
            end
        end
        if (w.func == cci_pkg::FUNC_PWR_TO_ADC) begin
            x = $signed(w.power);
            below = ys[0];
            above = ys[n - 1];
        end else begin
            x = w.adc;
            below = 0;
            above = max_tbl[w.curve];
        end
        if (xs[0] >= x) return below[7:0];
        if (xs[n - 1] < x) return above[7:0];
        i = 0;
        while (i < n && xs[i] <= x) i++;
        // query equal to the last point lands on that point
        if (i >= n) return ys[n - 1][7:0];
        x0 = xs[i - 1];
        dx = xs[i] - x0;
        dy = ys[i] - ys[i - 1];
        q = (ys[i - 1] * dx + (x - x0) * dy) / dx;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic cal_word_t random_word();
        cal_word_t w;
        w.func = cci_pkg::func_t'($urandom_range(0, 3));
        w.curve = 6'($urandom);
        w.point = 3'($urandom);
        w.power = 16'($urandom);
        w.adc = 8'($urandom);
        w.idx = 8'($urandom);
        w.maxi = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(input cal_word_t w, input logic use_table,
                             input logic [7:0] table_val);
        while (!quiet && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.func;
        s_tdata <= {7'd0, w.maxi, w.idx, w.adc, w.power, w.point, w.curve};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        case (w.func)
            cci_pkg::FUNC_WR_POINT: begin
                pwr_tbl[w.curve][w.point] = w.power;
                adc_tbl[w.curve][w.point] = w.adc;
                idx_tbl[w.curve][w.point] = w.idx;
            end
            cci_pkg::FUNC_WR_MAX: max_tbl[w.curve] = w.maxi;
            default: lookup_answers.push_back(use_table ? table_val : interpolate_curve(w));
        endcase
    endtask

    // ordered curve with random spacing, narrow or full range, plus its maximum
    task automatic write_curve(input logic [5:0] c);
        int        xp [$];
        int        xa [$];
        int        span, base, aspan, abase;
        cal_word_t w;
        span = $urandom_range(0, 1) ? 65535 : $urandom_range(8, 2000);
        base = $urandom_range(0, 65535 - span) - 32768;
        aspan = $urandom_range(0, 1) ? 255 : $urandom_range(8, 60);
        abase = $urandom_range(0, 255 - aspan);
        for (int k = 0; k < MAX_PTS; k++) begin
            xp.push_back(base + int'($urandom_range(0, span)));
            xa.push_back(abase + int'($urandom_range(0, aspan)));
        end
        xp.sort();
        xa.sort();
        for (int k = 0; k < MAX_PTS; k++) begin
            w = random_word();
            w.func = cci_pkg::FUNC_WR_POINT;
            w.curve = c;
            w.point = k[2:0];
            w.power = xp[k][15:0];
            w.adc = xa[k][7:0];
            send_word(w, 1'b0, 8'd0);
        end
        w = random_word();
        w.func = cci_pkg::FUNC_WR_MAX;
        w.curve = c;
        send_word(w, 1'b0, 8'd0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (lookup_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (lookup_answers.size() == 0) begin
                fails++;
                if (fails <= 10) $display("result word with none expected: %0d", m_tdata);
            end else begin
                want_word = lookup_answers.pop_front();
                if (m_tdata !== want_word) begin
                    fails++;
                    if (fails <= 10)
                        $display("result_value mismatch: expected %0d, got %0d",
                                 want_word, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_calibration_curve_interpolator: FAIL");
            $finish;
        end
    end

    initial begin
        cal_word_t w;
        int        pick, mode, n, k, lo, hi, q, phase_end;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= cci_pkg::FUNC_WR_POINT;
        cfg_we <= 1'b0;
        cfg_wdata <= cci_pkg::NUM_POINTS_RST;
        npts_reg = cci_pkg::NUM_POINTS_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            send_word(DIR_ROWS[r].word, DIR_ROWS[r].checked, DIR_ROWS[r].want);
        end
        drain_results();

        // every curve fully written before any random lookup
        for (int c = 0; c < NUM_CV; c++) write_curve(c[5:0]);

        foreach (NPTS_PLAN[ph]) begin
            drain_results();
            cfg_we <= 1'b1;
            cfg_wdata <= NPTS_PLAN[ph];
            @(posedge aclk);
            cfg_we <= 1'b0;
            npts_reg = NPTS_PLAN[ph];
            quiet = (ph == 2);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    write_curve(6'($urandom));
                end else if (pick < 7) begin
                    drain_results();
                end else begin
                    w = random_word();
                    if (pick < 17) begin
                        w.func = cci_pkg::FUNC_WR_POINT;
                    end else if (pick < 24) begin
                        w.func = cci_pkg::FUNC_WR_MAX;
                    end else begin
                        if ($urandom_range(0, 1)) w.func = cci_pkg::FUNC_PWR_TO_ADC;
                        else w.func = cci_pkg::FUNC_ADC_TO_IDX;
                        n = points_used();
                        k = $urandom_range(0, n - 2);
                        if (w.func == cci_pkg::FUNC_PWR_TO_ADC) begin
                            lo = pwr_tbl[w.curve][k];
                            hi = pwr_tbl[w.curve][k + 1];
                        end else begin
                            lo = adc_tbl[w.curve][k];
                            hi = adc_tbl[w.curve][k + 1];
                        end
                        // inside a segment, on a point, at a field extreme, or anywhere
                        mode = $urandom_range(0, 9);
                        if (mode < 4) q = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
                        else if (mode < 6) q = $urandom_range(0, 1) ? hi : lo;
                        else if (mode < 7) q = $urandom_range(0, 1) ? 32767 : -32768;
                        else q = $urandom;
                        if (w.func == cci_pkg::FUNC_PWR_TO_ADC) w.power = q[15:0];
                        else w.adc = q[7:0];
                    end
                    send_word(w, 1'b0, 8'd0);
                end
            end
        end

        drain_results();
        if (fails == 0 && lookup_answers.size() == 0)
            $display("tb_calibration_curve_interpolator: PASS");
        else
            $display("tb_calibration_curve_interpolator: FAIL");
        $finish;
    end

endmodule
